FILE: design/vt4_pkg.sv
// shared types and constants for the 4x4 vertex transform unit
package vt4_pkg;

  // matrix register file
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_W     = 64;

  // q16.16 data
  localparam int unsigned DATA_W = 32;
  localparam int unsigned LANES  = 4;
  localparam logic [DATA_W-1:0] ONE_Q16 = 32'h0001_0000;

  // identity matrix at reset, two entries per register, lower column in low half
  localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
  };

  // func codes
  typedef enum logic {
    FUNC_VEC4  = 1'b0,
    FUNC_POINT = 1'b1
  } func_e;

  typedef logic signed [DATA_W-1:0] q16_t;

  // per-stage load strobes shared by all lanes
  typedef struct packed {
    logic mul;
    logic pair;
    logic fin;
  } stage_en_t;

endpackage

FILE: design/vertex_transform_4x4_unit.sv
// top level: matrix registers, four row lanes, lane pipeline control, merge stage
//
// Transforms one Q16.16 vector per word by the 4x4 matrix held in eight 64-bit
// registers (identity after reset). Four row lanes run side by side; each lane
// has four 32x32 multipliers, then a pairwise add, then the final add with floor
// shift and clamp, and the merge stage registers the result word. Words pass
// the mul, pair, fin and output registers; throughput is one word per cycle
// unless stalled, limited by one multiplier-stage pass. Each stage moves on
// when it is empty or its successor moves, so bubbles close up, and a stalled
// output word still lets up to three more words enter behind it. in_stall_o
// follows out_stall_i combinationally when the pipeline is full. Matrix writes
// are always accepted and must only be issued while no word is in flight.
module vertex_transform_4x4_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [vt4_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [vt4_pkg::CFG_W-1:0]             cfg_data_i,
  // input channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  func_i,
  input  logic signed [vt4_pkg::DATA_W-1:0]     in_x_i,
  input  logic signed [vt4_pkg::DATA_W-1:0]     in_y_i,
  input  logic signed [vt4_pkg::DATA_W-1:0]     in_z_i,
  input  logic signed [vt4_pkg::DATA_W-1:0]     in_w_i,
  // output channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [vt4_pkg::DATA_W-1:0]     out_x_o,
  output logic signed [vt4_pkg::DATA_W-1:0]     out_y_o,
  output logic signed [vt4_pkg::DATA_W-1:0]     out_z_o,
  output logic signed [vt4_pkg::DATA_W-1:0]     out_w_o,
  output logic                                  saturated_o
);

  logic [vt4_pkg::CFG_W-1:0] cfg_q [vt4_pkg::NUM_REGS];

  logic [vt4_pkg::LANES-1:0][vt4_pkg::LANES-1:0][vt4_pkg::DATA_W-1:0] row_m;
  logic [vt4_pkg::LANES-1:0][vt4_pkg::DATA_W-1:0]                     vec;

  logic               v_mul_q, v_pair_q, v_fin_q;
  vt4_pkg::func_e     func_mul_q, func_pair_q, func_fin_q;
  logic               rdy_mul, rdy_pair, rdy_fin, rdy_out;
  vt4_pkg::stage_en_t en;

  vt4_pkg::q16_t               lane_res [vt4_pkg::LANES];
  logic [vt4_pkg::LANES-1:0]   lane_sat;

  // matrix registers, writes past the last register are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < vt4_pkg::NUM_REGS; i++) begin
        cfg_q[i] <= vt4_pkg::CFG_RESET[i];
      end
    end else if (cfg_valid_i && cfg_ready_o &&
                 (cfg_index_i < vt4_pkg::CFG_IDX_W'(vt4_pkg::NUM_REGS))) begin
      cfg_q[cfg_index_i[vt4_pkg::REG_IDX_W-1:0]] <= cfg_data_i;
    end
  end

  // unpack matrix entries per row
  always_comb begin
    for (int r = 0; r < vt4_pkg::LANES; r++) begin
      for (int c = 0; c < vt4_pkg::LANES; c++) begin
        row_m[r][c] = cfg_q[2*r + c/2][32*(c%2) +: 32];
      end
    end
  end

  // point mode takes w as one
  always_comb begin
    vec[0] = in_x_i;
    vec[1] = in_y_i;
    vec[2] = in_z_i;
    unique case (vt4_pkg::func_e'(func_i))
      vt4_pkg::FUNC_POINT: vec[3] = vt4_pkg::ONE_Q16;
      vt4_pkg::FUNC_VEC4:  vec[3] = in_w_i;
      default:             vec[3] = in_w_i;
    endcase
  end

  // stage handshake, each stage loads when empty or when its successor moves
  assign rdy_fin    = !v_fin_q  || rdy_out;
  assign rdy_pair   = !v_pair_q || rdy_fin;
  assign rdy_mul    = !v_mul_q  || rdy_pair;
  assign in_stall_o = !rdy_mul;

  assign en.mul  = in_valid_i && rdy_mul;
  assign en.pair = v_mul_q && rdy_pair;
  assign en.fin  = v_pair_q && rdy_fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_mul_q  <= 1'b0;
      v_pair_q <= 1'b0;
      v_fin_q  <= 1'b0;
    end else begin
      if (rdy_mul) begin
        v_mul_q <= in_valid_i;
      end
      if (rdy_pair) begin
        v_pair_q <= v_mul_q;
      end
      if (rdy_fin) begin
        v_fin_q <= v_pair_q;
      end
    end
  end

  // func travels alongside the lane data
  always_ff @(posedge clk_i) begin
    if (en.mul) begin
      func_mul_q <= vt4_pkg::func_e'(func_i);
    end
    if (en.pair) begin
      func_pair_q <= func_mul_q;
    end
    if (en.fin) begin
      func_fin_q <= func_pair_q;
    end
  end

  // one lane per matrix row
  for (genvar r = 0; r < vt4_pkg::LANES; r++) begin : g_lane
    vt4_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .row_i (row_m[r]),
      .vec_i (vec),
      .res_o (lane_res[r]),
      .sat_o (lane_sat[r])
    );
  end

  // merge lane results into the output word
  vt4_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (v_fin_q),
    .func_i      (func_fin_q),
    .res_i       (lane_res),
    .sat_i       (lane_sat),
    .out_stall_i (out_stall_i),
    .ready_o     (rdy_out),
    .out_valid_o (out_valid_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .out_w_o     (out_w_o),
    .saturated_o (saturated_o)
  );

endmodule

FILE: design/vt4_lane.sv
// one row lane: four products, pair sums, final sum with floor shift and clamp
module vt4_lane (
  input  logic                                         clk_i,
  input  vt4_pkg::stage_en_t                           en_i,
  input  logic [vt4_pkg::LANES-1:0][vt4_pkg::DATA_W-1:0] row_i,
  input  logic [vt4_pkg::LANES-1:0][vt4_pkg::DATA_W-1:0] vec_i,
  output vt4_pkg::q16_t                                res_o,
  output logic                                         sat_o
);

  logic signed [63:0] prod_d [vt4_pkg::LANES];
  logic signed [63:0] prod_q [vt4_pkg::LANES];
  logic signed [64:0] pair_d [2];
  logic signed [64:0] pair_q [2];
  logic signed [65:0] sum;
  logic        [49:0] shifted;
  logic               pos_ovf;
  logic               neg_ovf;
  vt4_pkg::q16_t      res_d;
  vt4_pkg::q16_t      res_q;
  logic               sat_d;
  logic               sat_q;

  // exact q32.32 products, one multiplier per column
  always_comb begin
    for (int c = 0; c < vt4_pkg::LANES; c++) begin
      prod_d[c] = vt4_pkg::q16_t'(row_i[c]) * vt4_pkg::q16_t'(vec_i[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      for (int c = 0; c < vt4_pkg::LANES; c++) begin
        prod_q[c] <= prod_d[c];
      end
    end
  end

  // pairwise sums
  always_comb begin
    pair_d[0] = 65'(prod_q[0]) + 65'(prod_q[1]);
    pair_d[1] = 65'(prod_q[2]) + 65'(prod_q[3]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.pair) begin
      pair_q[0] <= pair_d[0];
      pair_q[1] <= pair_d[1];
    end
  end

  // final sum, arithmetic shift by 16 (floor), clamp to 32 bits
  always_comb begin
    sum     = 66'(pair_q[0]) + 66'(pair_q[1]);
    shifted = sum[65:16];
    pos_ovf = !shifted[49] && (|shifted[48:31]);
    neg_ovf = shifted[49] && !(&shifted[48:31]);
    priority if (pos_ovf) begin
      res_d = 32'sh7FFF_FFFF;
    end else if (neg_ovf) begin
      res_d = 32'sh8000_0000;
    end else begin
      res_d = shifted[31:0];
    end
    sat_d = pos_ovf || neg_ovf;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.fin) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule

FILE: design/vt4_merge.sv
// merge stage: gathers the four lane results into the output word register
module vt4_merge (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  vt4_pkg::func_e                        func_i,
  input  vt4_pkg::q16_t                         res_i [vt4_pkg::LANES],
  input  logic [vt4_pkg::LANES-1:0]             sat_i,
  input  logic                                  out_stall_i,
  output logic                                  ready_o,
  output logic                                  out_valid_o,
  output logic signed [vt4_pkg::DATA_W-1:0]     out_x_o,
  output logic signed [vt4_pkg::DATA_W-1:0]     out_y_o,
  output logic signed [vt4_pkg::DATA_W-1:0]     out_z_o,
  output logic signed [vt4_pkg::DATA_W-1:0]     out_w_o,
  output logic                                  saturated_o
);

  logic          out_valid_q;
  logic          load;
  vt4_pkg::q16_t w_d;
  logic          sat_d;
  vt4_pkg::q16_t x_q, y_q, z_q, w_q;
  logic          sat_q;

  // output register frees up when empty or when the word is taken
  assign ready_o = !out_valid_q || !out_stall_i;
  assign load    = valid_i && ready_o;

  // point mode drops row 3 from both w and the clamp flag
  always_comb begin
    unique case (func_i)
      vt4_pkg::FUNC_POINT: begin
        w_d   = '0;
        sat_d = |sat_i[2:0];
      end
      vt4_pkg::FUNC_VEC4: begin
        w_d   = res_i[3];
        sat_d = |sat_i;
      end
      default: begin
        w_d   = res_i[3];
        sat_d = |sat_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_o) begin
      out_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q   <= res_i[0];
      y_q   <= res_i[1];
      z_q   <= res_i[2];
      w_q   <= w_d;
      sat_q <= sat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = x_q;
  assign out_y_o     = y_q;
  assign out_z_o     = z_q;
  assign out_w_o     = w_q;
  assign saturated_o = sat_q;

endmodule

FILE: design/vt4_checker.sv
// port-level checks for the vertex transform unit, bound to the top level
module vt4_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [vt4_pkg::DATA_W-1:0] out_x_o,
  input logic signed [vt4_pkg::DATA_W-1:0] out_y_o,
  input logic signed [vt4_pkg::DATA_W-1:0] out_z_o,
  input logic signed [vt4_pkg::DATA_W-1:0] out_w_o,
  input logic                              saturated_o
);

  // a stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_x_o) && $stable(out_y_o) &&
      $stable(out_z_o) && $stable(out_w_o) && $stable(saturated_o))
  else $error("stalled output word changed");

  // input only backs up behind a stalled, full output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
  else $error("input stalled while output side can move");

  // a clamp flag comes with at least one component at a rail
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      out_x_o == 32'sh7FFF_FFFF || out_x_o == 32'sh8000_0000 ||
      out_y_o == 32'sh7FFF_FFFF || out_y_o == 32'sh8000_0000 ||
      out_z_o == 32'sh7FFF_FFFF || out_z_o == 32'sh8000_0000 ||
      out_w_o == 32'sh7FFF_FFFF || out_w_o == 32'sh8000_0000)
  else $error("saturated flag without a clamped component");

  // pipeline is empty coming out of reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
  else $error("output valid right after reset");

endmodule

bind vertex_transform_4x4_unit vt4_checker u_vt4_checker (.*);

FILE: tb/sv/vertex_transform_4x4_unit_tb.sv
// self-checking testbench for the 4x4 vertex transform unit
module vertex_transform_4x4_unit_tb;
  import vt4_pkg::*;

  // one input word and one result word
  typedef struct {
    func_e func;
    q16_t  x;
    q16_t  y;
    q16_t  z;
    q16_t  w;
  } vertex_t;

  typedef struct {
    q16_t x;
    q16_t y;
    q16_t z;
    q16_t w;
    logic sat;
  } xform_t;

  localparam logic signed [65:0] ROW_MAX = 66'sd2147483647;
  localparam logic signed [65:0] ROW_MIN = -66'sd2147483648;
  localparam q16_t Q_MAX = 32'sh7FFF_FFFF;
  localparam q16_t Q_MIN = 32'sh8000_0000;
  localparam q16_t Q_ONE = 32'sh0001_0000;
  localparam q16_t Q_NEG = -32'sd1;
  localparam q16_t Q_LSB = 32'sd1;
  localparam q16_t Q_ZERO = 32'sd0;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 func_i;
  q16_t                 in_x_i;
  q16_t                 in_y_i;
  q16_t                 in_z_i;
  q16_t                 in_w_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  q16_t                 out_x_o;
  q16_t                 out_y_o;
  q16_t                 out_z_o;
  q16_t                 out_w_o;
  logic                 saturated_o;

  // predictor state and scoreboard
  logic [CFG_W-1:0] matrix_regs [NUM_REGS];
  xform_t           pending_xforms [$];
  int               error_count   = 0;
  int               receiver_hold = 0;
  bit               quiet_mode    = 1'b0;

  vertex_transform_4x4_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .in_x_i      (in_x_i),
    .in_y_i      (in_y_i),
    .in_z_i      (in_z_i),
    .in_w_i      (in_w_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .out_w_o     (out_w_o),
    .saturated_o (saturated_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("vertex_transform_4x4_unit_tb: errors");
    $finish;
  end

  // exact row sums, floor shift by 16, clamp to 32 bits
  function automatic xform_t transform_vertex(vertex_t v);
    logic signed [65:0] vec [4];
    logic signed [65:0] acc;
    logic signed [65:0] entry;
    logic signed [65:0] row_val;
    logic [CFG_W-1:0]   word;
    q16_t               lane [4];
    xform_t             r;
    vec[0] = v.x;
    vec[1] = v.y;
    vec[2] = v.z;
    if (v.func == FUNC_POINT) begin
      vec[3] = Q_ONE;
    end else begin
      vec[3] = v.w;
    end
    r.sat = 1'b0;
    for (int row = 0; row < 4; row++) begin
      lane[row] = Q_ZERO;
      // row 3 is not computed for points
      if (!(row == 3 && v.func == FUNC_POINT)) begin
        acc = '0;
        for (int col = 0; col < 4; col++) begin
          word = matrix_regs[row * 2 + col / 2];
          if (col % 2 == 1) begin
            entry = q16_t'(word[63:32]);
          end else begin
            entry = q16_t'(word[31:0]);
          end
          acc = acc + entry * vec[col];
        end
        row_val = acc >>> 16;
        if (row_val > ROW_MAX) begin
          lane[row] = Q_MAX;
          r.sat     = 1'b1;
        end else if (row_val < ROW_MIN) begin
          lane[row] = Q_MIN;
          r.sat     = 1'b1;
        end else begin
          lane[row] = q16_t'(row_val[31:0]);
        end
      end
    end
    r.x = lane[0];
    r.y = lane[1];
    r.z = lane[2];
    r.w = lane[3];
    return r;
  endfunction

  function automatic vertex_t make_vertex(func_e f, q16_t x, q16_t y, q16_t z, q16_t w);
    vertex_t v;
    v.func = f;
    v.x    = x;
    v.y    = y;
    v.z    = z;
    v.w    = w;
    return v;
  endfunction

  // value classes: full range, small, moderate and corner values
  function automatic q16_t rand_q16();
    q16_t val;
    case ($urandom_range(0, 7))
      0, 1, 2: val = q16_t'($urandom);
      3, 4:    val = q16_t'($urandom_range(0, 32'h7FFFF)) - 32'sh3FFFF;
      5: begin
        case ($urandom_range(0, 5))
          0:       val = Q_MIN;
          1:       val = Q_MAX;
          2:       val = Q_ZERO;
          3:       val = Q_NEG;
          4:       val = Q_LSB;
          default: val = Q_ONE;
        endcase
      end
      default: val = q16_t'($urandom_range(0, 32'hFFFFFF)) - 32'sh7FFFFF;
    endcase
    return val;
  endfunction

  function automatic vertex_t rand_vertex();
    return make_vertex(func_e'($urandom_range(0, 1)), rand_q16(), rand_q16(),
                       rand_q16(), rand_q16());
  endfunction

  function automatic logic [CFG_W-1:0] rand_cfg_word(int kind);
    logic [CFG_W-1:0] word;
    case (kind)
      0:       word = {32'($urandom_range(0, 32'h1FFFF) - 32'h10000),
                       32'($urandom_range(0, 32'h1FFFF) - 32'h10000)};
      1:       word = {$urandom, $urandom};
      default: word = {rand_q16(), rand_q16()};
    endcase
    return word;
  endfunction

  // compare one field of a result word
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin : result_check
    xform_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_xforms.size() == 0) begin
        $display("%0t: result word with nothing expected, expected none actual %h %h %h %h %b",
                 $time, out_x_o, out_y_o, out_z_o, out_w_o, saturated_o);
        error_count++;
      end else begin
        want = pending_xforms.pop_front();
        check_field("out_x", want.x, out_x_o);
        check_field("out_y", want.y, out_y_o);
        check_field("out_z", want.z, out_z_o);
        check_field("out_w", want.w, out_w_o);
        check_field("saturated", {31'b0, want.sat}, {31'b0, saturated_o});
      end
    end
  end

  // receiver stall: long hold on request, none in quiet mode, otherwise random short and long stalls
  initial begin : receiver_stall
    int burst;
    burst = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (receiver_hold > 0) begin
        out_stall_i   <= 1'b1;
        receiver_hold = receiver_hold - 1;
      end else if (quiet_mode) begin
        out_stall_i <= 1'b0;
      end else if (burst > 0) begin
        out_stall_i <= 1'b1;
        burst       = burst - 1;
      end else if ($urandom_range(0, 49) == 0) begin
        out_stall_i <= 1'b1;
        burst       = $urandom_range(8, 40);
      end else begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  // offer one word and hold it until accepted
  task automatic send_vertex(input vertex_t v);
    in_valid_i <= 1'b1;
    func_i     <= v.func;
    in_x_i     <= v.x;
    in_y_i     <= v.y;
    in_z_i     <= v.z;
    in_w_i     <= v.w;
    do @(posedge clk_i); while (in_stall_o);
    pending_xforms.push_back(transform_vertex(v));
  endtask

  task automatic pause_input(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // random sender gap, mostly none or short
  task automatic input_gap();
    int r;
    int n;
    n = 0;
    r = $urandom_range(0, 19);
    if (!quiet_mode) begin
      if (r >= 18) begin
        n = $urandom_range(8, 30);
      end else if (r >= 12) begin
        n = $urandom_range(1, 3);
      end
    end
    if (n > 0) begin
      pause_input(n);
    end
  endtask

  // stop sending until every expected word has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_xforms.size() != 0);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    // indexes past the register file are dropped
    if (idx < NUM_REGS) begin
      matrix_regs[idx] = data;
    end
  endtask

  task automatic load_matrix(input logic [CFG_W-1:0] words [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) begin
      write_cfg(CFG_IDX_W'(i), words[i]);
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_list(input vertex_t list [$]);
    foreach (list[i]) begin
      send_vertex(list[i]);
      input_gap();
    end
  endtask

  // identity matrix after reset, corner inputs in both modes
  task automatic test_reset_identity();
    vertex_t list [$];
    list.push_back(make_vertex(FUNC_VEC4, Q_MAX, Q_MIN, Q_ZERO, Q_NEG));
    list.push_back(make_vertex(FUNC_POINT, Q_MIN, Q_MAX, Q_NEG, Q_MAX));
    list.push_back(make_vertex(FUNC_VEC4, Q_LSB, Q_NEG, Q_ONE, Q_MIN));
    list.push_back(make_vertex(FUNC_POINT, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO));
    send_list(list);
  endtask

  // extreme matrices, clamping in both directions
  task automatic test_saturation();
    logic [CFG_W-1:0] m [NUM_REGS];
    vertex_t          list [$];
    drain_results();
    m = '{default: 64'h8000_0000_8000_0000};
    load_matrix(m);
    list.push_back(make_vertex(FUNC_VEC4, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    list.push_back(make_vertex(FUNC_VEC4, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    list.push_back(make_vertex(FUNC_POINT, Q_MIN, Q_MAX, Q_MIN, Q_ZERO));
    list.push_back(make_vertex(FUNC_VEC4, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO));
    send_list(list);
    drain_results();
    m = '{default: 64'h7FFF_FFFF_7FFF_FFFF};
    load_matrix(m);
    list = {};
    list.push_back(make_vertex(FUNC_VEC4, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    list.push_back(make_vertex(FUNC_POINT, Q_MIN, Q_MIN, Q_MIN, Q_MAX));
    send_list(list);
    drain_results();
    m = '{default: 64'h0};
    load_matrix(m);
    send_vertex(make_vertex(FUNC_VEC4, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
    drain_results();
    m = '{default: 64'hFFFF_FFFF_FFFF_FFFF};
    load_matrix(m);
    send_vertex(make_vertex(FUNC_VEC4, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    input_gap();
  endtask

  // truncation of negative sums goes toward minus infinity
  task automatic test_floor_shift();
    logic [CFG_W-1:0] m [NUM_REGS];
    vertex_t          list [$];
    drain_results();
    m = '{default: 64'h0000_0001_0000_0001};
    load_matrix(m);
    list.push_back(make_vertex(FUNC_VEC4, Q_NEG, Q_ZERO, Q_ZERO, Q_ZERO));
    list.push_back(make_vertex(FUNC_VEC4, Q_NEG, Q_NEG, Q_NEG, Q_NEG));
    list.push_back(make_vertex(FUNC_VEC4, Q_LSB, Q_LSB, Q_LSB, Q_LSB));
    list.push_back(make_vertex(FUNC_POINT, Q_NEG, Q_ZERO, Q_ZERO, Q_MIN));
    send_list(list);
  endtask

  // point mode: w ignored, translation added, row 3 out of the flag
  task automatic test_point_mode();
    logic [CFG_W-1:0] m [NUM_REGS];
    vertex_t          list [$];
    drain_results();
    m = CFG_RESET;
    m[1] = 64'h0003_0000_0000_0000;
    m[6] = 64'h7FFF_FFFF_7FFF_FFFF;
    m[7] = 64'h7FFF_FFFF_7FFF_FFFF;
    load_matrix(m);
    list.push_back(make_vertex(FUNC_VEC4, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    list.push_back(make_vertex(FUNC_POINT, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    list.push_back(make_vertex(FUNC_POINT, Q_ONE, Q_NEG, Q_ZERO, Q_MIN));
    send_list(list);
  endtask

  // writes past the register file leave the matrix alone
  task automatic test_bad_index();
    drain_results();
    for (int i = NUM_REGS; i < (1 << CFG_IDX_W); i++) begin
      write_cfg(CFG_IDX_W'(i), {$urandom, $urandom});
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    send_vertex(rand_vertex());
    input_gap();
    send_vertex(rand_vertex());
    input_gap();
  endtask

  // receiver holds off while words keep coming, then a full drain
  task automatic test_backpressure();
    logic [CFG_W-1:0] m [NUM_REGS];
    drain_results();
    foreach (m[i]) begin
      m[i] = rand_cfg_word(2);
    end
    load_matrix(m);
    receiver_hold = 80;
    repeat (20) send_vertex(rand_vertex());
    drain_results();
  endtask

  // random phases, each with its own matrix
  task automatic test_random_phases();
    logic [CFG_W-1:0] m [NUM_REGS];
    for (int phase = 0; phase < 8; phase++) begin
      drain_results();
      foreach (m[i]) begin
        m[i] = rand_cfg_word(phase % 3);
      end
      load_matrix(m);
      quiet_mode = (phase == 2 || phase == 5);
      repeat (100) begin
        send_vertex(rand_vertex());
        input_gap();
      end
    end
    quiet_mode = 1'b0;
  endtask

  // sequence
  initial begin
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    func_i      <= FUNC_VEC4;
    in_x_i      <= '0;
    in_y_i      <= '0;
    in_z_i      <= '0;
    in_w_i      <= '0;
    matrix_regs = CFG_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_identity();
    test_saturation();
    test_floor_shift();
    test_point_mode();
    test_bad_index();
    test_backpressure();
    test_random_phases();

    drain_results();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("vertex_transform_4x4_unit_tb: clean");
    end else begin
      $display("vertex_transform_4x4_unit_tb: errors");
    end
    $finish;
  end

endmodule
